/* src/fk_pkg.sv */
// shared types and constants of the two-link forward kinematics unit
`timescale 1ns / 1ps
package fk_pkg;

  localparam int ZW = 26;             // angle in q16 degrees, signed
  localparam int XW = 34;             // cordic x and y in q30, signed
  localparam int CORDIC_STEPS = 16;
  localparam int LINK_W = 10;

  localparam logic signed [XW-1:0] CORDIC_K    = 34'sd652032875;
  localparam logic signed [ZW-1:0] QUARTER_Q16 = 26'sd5898240;
  localparam logic signed [ZW-1:0] HALF_Q16    = 26'sd11796480;
  localparam logic signed [ZW-1:0] TURN_Q16    = 26'sd23592960;

  typedef enum logic [2:0] {
    REG_BASE_LINK   = 3'd0,
    REG_LOWER_LINK  = 3'd1,
    REG_UPPER_LINK  = 3'd2,
    REG_LOWER_ZERO  = 3'd3,
    REG_UPPER_ZERO  = 3'd4,
    REG_LOWER_DPC   = 3'd5,
    REG_UPPER_DPC   = 3'd6,
    REG_NONE        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]         lower_zero;
    logic [9:0]         upper_zero;
    logic signed [15:0] lower_dpc;
    logic signed [15:0] upper_dpc;
  } cal_cfg_t;

  typedef struct packed {
    logic [LINK_W-1:0] base_link;
    logic [LINK_W-1:0] lower_link;
    logic [LINK_W-1:0] upper_link;
  } link_cfg_t;

  typedef struct packed {
    logic                vld;
    logic                neg;
    logic signed [ZW-1:0] z;
  } ang_t;

  typedef struct packed {
    logic                vld;
    logic                neg;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
  } trig_t;

  // atan(2^-i) in q16 degrees
  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/fk_angle.sv */
// joint calibration, angle sum, reduction modulo one turn and fold to +-90 degrees
`timescale 1ns / 1ps
module fk_angle #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [ADC_BITS-1:0] lower_sample,
  input  logic [ADC_BITS-1:0] upper_sample,
  input  fk_pkg::cal_cfg_t    cfg,
  output fk_pkg::ang_t        ang1_o,
  output fk_pkg::ang_t        ang2_o
);
  import fk_pkg::*;

  localparam int DW = ADC_BITS + 1;
  localparam int AW = ADC_BITS + 17;
  localparam int SW = ADC_BITS + 19;
  localparam int W  = ADC_BITS + 9;
  localparam int S  = W + 7;
  localparam int RW = W + 3;
  localparam int QW = W - 5;
  localparam logic [W-1:0]  OFFSET = W'(45 * (longint'(1) << (ADC_BITS + 3)));
  localparam logic [RW-1:0] RECIP  = RW'(((longint'(1) << S) + 44) / 45);
  localparam logic signed [SW-1:0] OFS_90_Q12 = SW'(368640);

  logic [7:1]                vld_r;
  logic signed [DW-1:0]      d_r   [0:1];
  logic signed [AW-1:0]      a_r   [0:1];
  logic signed [SW-1:0]      b_r   [0:1];
  logic [W-1:0]              u_r   [0:1];
  logic [W-1:0]              u5_r  [0:1];
  logic [14:0]               lo4_r [0:1];
  logic [14:0]               lo5_r [0:1];
  logic [QW-1:0]             q_r   [0:1];
  logic [20:0]               m_r   [0:1];
  logic signed [ZW-1:0]      z_r   [0:1];
  logic [1:0]                neg_r;

  logic [ADC_BITS-1:0]       zero_e [0:1];
  logic [ADC_BITS-1:0]       smp    [0:1];
  logic signed [15:0]        dpc    [0:1];
  logic [W+RW-1:0]           uq     [0:1];
  logic [W-1:0]              rem    [0:1];
  logic signed [ZW-1:0]      zw     [0:1];
  logic signed [ZW-1:0]      z_nxt  [0:1];
  logic [1:0]                neg_nxt;

  always_comb begin
    zero_e[0] = ADC_BITS'(cfg.lower_zero);
    zero_e[1] = ADC_BITS'(cfg.upper_zero);
    smp[0]    = lower_sample;
    smp[1]    = upper_sample;
    dpc[0]    = cfg.lower_dpc;
    dpc[1]    = cfg.upper_dpc;
    for (int k = 0; k < 2; k++) begin
      uq[k]  = u_r[k] * RECIP;
      rem[k] = u5_r[k] - W'(q_r[k]) * W'(6'd45);
      // m is in [0, 360) degrees q12, scale to q16 then wrap to [-180, 180)
      zw[k]  = signed'({1'b0, m_r[k], 4'b0000});
      if (zw[k] >= HALF_Q16) begin
        zw[k] = zw[k] - TURN_Q16;
      end
      neg_nxt[k] = 1'b0;
      z_nxt[k]   = zw[k];
      if (zw[k] > QUARTER_Q16) begin
        z_nxt[k]   = zw[k] - HALF_Q16;
        neg_nxt[k] = 1'b1;
      end else if (zw[k] < -QUARTER_Q16) begin
        z_nxt[k]   = zw[k] + HALF_Q16;
        neg_nxt[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      d_r[k]   <= signed'({1'b0, smp[k]}) - signed'({1'b0, zero_e[k]});
      a_r[k]   <= d_r[k] * dpc[k];
      u_r[k]   <= W'(signed'(b_r[k][SW-1:15])) + OFFSET;
      lo4_r[k] <= b_r[k][14:0];
      q_r[k]   <= uq[k][S +: QW];
      u5_r[k]  <= u_r[k];
      lo5_r[k] <= lo4_r[k];
      m_r[k]   <= {rem[k][5:0], lo5_r[k]};
      z_r[k]   <= z_nxt[k];
    end
    b_r[0] <= SW'(a_r[0]);
    b_r[1] <= SW'(a_r[0]) + SW'(a_r[1]) - OFS_90_Q12;
    neg_r  <= neg_nxt;
  end

  assign ang1_o = '{vld: vld_r[7], neg: neg_r[0], z: z_r[0]};
  assign ang2_o = '{vld: vld_r[7], neg: neg_r[1], z: z_r[1]};

`ifndef SYNTHESIS
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    ang1_o.vld |-> (ang1_o.z <= QUARTER_Q16 && ang1_o.z >= -QUARTER_Q16 &&
                    ang2_o.z <= QUARTER_Q16 && ang2_o.z >= -QUARTER_Q16))
    else $error("folded angle outside quarter turn");
`endif

endmodule

/* src/fk_cordic.sv */
// sixteen-stage pipelined rotation cordic giving cos and sin in q30
`timescale 1ns / 1ps
module fk_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  fk_pkg::ang_t  ang_i,
  output fk_pkg::trig_t trig_o
);
  import fk_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [XW-1:0] x_r [1:N];
  logic signed [XW-1:0] y_r [1:N];
  logic signed [ZW-1:0] z_r [1:N];
  logic [N:1]           neg_r;
  logic [N:1]           vld_r;

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic signed [XW-1:0] xp, yp, x_nxt, y_nxt;
    logic signed [ZW-1:0] zp, z_nxt;
    logic                 np, vp;

    if (g == 0) begin : g_first
      assign xp = CORDIC_K;
      assign yp = '0;
      assign zp = ang_i.z;
      assign np = ang_i.neg;
      assign vp = ang_i.vld;
    end else begin : g_next
      assign xp = x_r[g];
      assign yp = y_r[g];
      assign zp = z_r[g];
      assign np = neg_r[g];
      assign vp = vld_r[g];
    end

    always_comb begin
      if (!zp[ZW-1]) begin
        x_nxt = xp - (yp >>> g);
        y_nxt = yp + (xp >>> g);
        z_nxt = zp - atan_q16(g);
      end else begin
        x_nxt = xp + (yp >>> g);
        y_nxt = yp - (xp >>> g);
        z_nxt = zp + atan_q16(g);
      end
    end

    always_ff @(posedge clk) begin
      x_r[g+1]   <= x_nxt;
      y_r[g+1]   <= y_nxt;
      z_r[g+1]   <= z_nxt;
      neg_r[g+1] <= np;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vp;
      end
    end
  end

  assign trig_o = '{vld: vld_r[N], neg: neg_r[N], x: x_r[N], y: y_r[N]};

`ifndef SYNTHESIS
  a_cordic_latency: assert property (@(posedge clk) disable iff (!rst_n)
    trig_o.vld |-> $past(ang_i.vld, 16))
    else $error("cordic valid without matching entry");
`endif

endmodule

/* src/fk_combine.sv */
// link length products, coordinate sums, rounding and saturation
`timescale 1ns / 1ps
module fk_combine #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fk_pkg::trig_t                 t1_i,
  input  fk_pkg::trig_t                 t2_i,
  input  fk_pkg::link_cfg_t             links,
  output logic                          vld_o,
  output logic signed [COORD_WIDTH-1:0] pos_x_o,
  output logic signed [COORD_WIDTH-1:0] pos_y_o,
  output logic                          sat_o
);
  import fk_pkg::*;

  localparam int PW  = XW + 15;
  localparam int SSW = PW + 3;
  localparam int VW  = SSW - 30;
  localparam int EW  = VW + COORD_WIDTH;
  localparam logic signed [EW-1:0] HI = EW'((longint'(1) <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [EW-1:0] LO = -HI - EW'(1);
  localparam logic signed [SSW-1:0] HALF_LSB = SSW'(longint'(1) <<< 29);

  logic signed [PW-1:0]          px2_r, px3_r, py2_r, py3_r;
  logic [1:0]                    neg_r;
  logic                          vld_a_r, vld_r;
  logic signed [COORD_WIDTH-1:0] pos_x_r, pos_y_r;
  logic                          sat_r;

  logic signed [14:0]            l2s, l3s;
  logic signed [SSW-1:0]         base, t2x, t3x, t2y, t3y, sx, sy;
  logic signed [EW-1:0]          vx, vy;
  logic signed [COORD_WIDTH-1:0] pos_x_nxt, pos_y_nxt;
  logic                          sat_nxt;

  always_comb begin
    l2s  = signed'({1'b0, links.lower_link, 4'b0000});
    l3s  = signed'({1'b0, links.upper_link, 4'b0000});
    base = SSW'(signed'({1'b0, links.base_link, 34'd0}));
    t2x  = neg_r[0] ? -SSW'(px2_r) : SSW'(px2_r);
    t3x  = neg_r[1] ? -SSW'(px3_r) : SSW'(px3_r);
    t2y  = neg_r[0] ? -SSW'(py2_r) : SSW'(py2_r);
    t3y  = neg_r[1] ? -SSW'(py3_r) : SSW'(py3_r);
    sx   = t2x + t3x + HALF_LSB;
    sy   = base + t2y + t3y + HALF_LSB;
    vx   = EW'(signed'(sx[SSW-1:30]));
    vy   = EW'(signed'(sy[SSW-1:30]));
    sat_nxt   = 1'b0;
    pos_x_nxt = COORD_WIDTH'(vx);
    pos_y_nxt = COORD_WIDTH'(vy);
    if (vx > HI) begin
      pos_x_nxt = COORD_WIDTH'(HI);
      sat_nxt   = 1'b1;
    end else if (vx < LO) begin
      pos_x_nxt = COORD_WIDTH'(LO);
      sat_nxt   = 1'b1;
    end
    if (vy > HI) begin
      pos_y_nxt = COORD_WIDTH'(HI);
      sat_nxt   = 1'b1;
    end else if (vy < LO) begin
      pos_y_nxt = COORD_WIDTH'(LO);
      sat_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    px2_r   <= l2s * t1_i.x;
    px3_r   <= l3s * t2_i.x;
    py2_r   <= l2s * t1_i.y;
    py3_r   <= l3s * t2_i.y;
    neg_r   <= {t2_i.neg, t1_i.neg};
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    sat_r   <= sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      vld_a_r <= t1_i.vld;
      vld_r   <= vld_a_r;
    end
  end

  assign vld_o   = vld_r;
  assign pos_x_o = pos_x_r;
  assign pos_y_o = pos_y_r;
  assign sat_o   = sat_r;

endmodule

/* src/two_link_forward_kinematics_unit.sv */
// top level: config registers and the kinematics pipeline
//
// Two-link planar forward kinematics. Give a pair of joint ADC samples on
// in_lower_sample / in_upper_sample with start high; busy is always low, so
// an item is taken at every edge where start is high, one per cycle.
// Each item gives one result: out_pos_x, out_pos_y (1/16 mm, saturated)
// and out_saturated, shown for one cycle with out_valid high.
// The pipeline has 7 calibration and angle-reduction stages, 16 cordic
// stages (one iteration each, two lanes side by side) and 2 product and
// rounding stages. Throughput is one item per cycle.
// The receiver cannot stall; out_valid simply marks the cycle of the result.
// Link lengths, zero counts and degrees per count sit on the apb-style
// port (byte address 4*index); change them only with no item in flight.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// register defaults.
`timescale 1ns / 1ps
module two_link_forward_kinematics_unit #(
  parameter int ADC_BITS    = 10,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ADC_BITS-1:0]           in_lower_sample,
  input  logic [ADC_BITS-1:0]           in_upper_sample,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_pos_x,
  output logic signed [COORD_WIDTH-1:0] out_pos_y,
  output logic                          out_saturated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fk_pkg::*;

  logic [9:0]         base_link_r, lower_link_r, upper_link_r;
  logic [9:0]         lower_zero_r, upper_zero_r;
  logic signed [15:0] lower_dpc_r, upper_dpc_r;
  logic               wr_en;
  reg_idx_t           idx;
  cal_cfg_t           cal_cfg;
  link_cfg_t          link_cfg;
  ang_t               ang1, ang2;
  trig_t              trig1, trig2;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_link_r  <= 10'd100;
      lower_link_r <= 10'd150;
      upper_link_r <= 10'd150;
      lower_zero_r <= 10'd0;
      upper_zero_r <= 10'd0;
      lower_dpc_r  <= 16'sd1474;
      upper_dpc_r  <= 16'sd1474;
    end else if (wr_en) begin
      case (idx)
        REG_BASE_LINK:  base_link_r  <= pwdata[9:0];
        REG_LOWER_LINK: lower_link_r <= pwdata[9:0];
        REG_UPPER_LINK: upper_link_r <= pwdata[9:0];
        REG_LOWER_ZERO: lower_zero_r <= pwdata[9:0];
        REG_UPPER_ZERO: upper_zero_r <= pwdata[9:0];
        REG_LOWER_DPC:  lower_dpc_r  <= signed'(pwdata[15:0]);
        REG_UPPER_DPC:  upper_dpc_r  <= signed'(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE_LINK:  prdata = {22'd0, base_link_r};
      REG_LOWER_LINK: prdata = {22'd0, lower_link_r};
      REG_UPPER_LINK: prdata = {22'd0, upper_link_r};
      REG_LOWER_ZERO: prdata = {22'd0, lower_zero_r};
      REG_UPPER_ZERO: prdata = {22'd0, upper_zero_r};
      REG_LOWER_DPC:  prdata = {16'd0, lower_dpc_r};
      REG_UPPER_DPC:  prdata = {16'd0, upper_dpc_r};
      default:        prdata = '0;
    endcase
  end

  assign cal_cfg  = '{lower_zero: lower_zero_r, upper_zero: upper_zero_r,
                      lower_dpc: lower_dpc_r, upper_dpc: upper_dpc_r};
  assign link_cfg = '{base_link: base_link_r, lower_link: lower_link_r,
                      upper_link: upper_link_r};

  fk_angle #(.ADC_BITS(ADC_BITS)) u_angle (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (start & ~busy),
    .lower_sample (in_lower_sample),
    .upper_sample (in_upper_sample),
    .cfg          (cal_cfg),
    .ang1_o       (ang1),
    .ang2_o       (ang2)
  );

  fk_cordic u_cordic1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .ang_i  (ang1),
    .trig_o (trig1)
  );

  fk_cordic u_cordic2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .ang_i  (ang2),
    .trig_o (trig2)
  );

  fk_combine #(.COORD_WIDTH(COORD_WIDTH)) u_combine (
    .clk     (clk),
    .rst_n   (rst_n),
    .t1_i    (trig1),
    .t2_i    (trig2),
    .links   (link_cfg),
    .vld_o   (out_valid),
    .pos_x_o (out_pos_x),
    .pos_y_o (out_pos_y),
    .sat_o   (out_saturated)
  );

`ifndef SYNTHESIS
  a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 25))
    else $error("result without an accepted item");
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_pos_x == {1'b0, {(COORD_WIDTH-1){1'b1}}} ||
       out_pos_x == {1'b1, {(COORD_WIDTH-1){1'b0}}} ||
       out_pos_y == {1'b0, {(COORD_WIDTH-1){1'b1}}} ||
       out_pos_y == {1'b1, {(COORD_WIDTH-1){1'b0}}}))
    else $error("saturated flag without a clamped coordinate");
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    trig1.vld == trig2.vld)
    else $error("cordic lanes out of step");
`endif

endmodule

/* tb/testbench.sv */
// self-checking testbench of the two-link forward kinematics unit
`timescale 1ns / 1ps
module testbench;
  import fk_pkg::*;

  typedef struct {
    logic [9:0] lower;
    logic [9:0] upper;
  } sample_pair_t;

  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               sat;
  } position_t;

  typedef bit bool_t;

  localparam int LATENCY = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [9:0] in_lower_sample = '0;
  logic [9:0] in_upper_sample = '0;
  logic out_valid;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic out_saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  two_link_forward_kinematics_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_lower_sample(in_lower_sample), .in_upper_sample(in_upper_sample),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_saturated(out_saturated), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // local copy of the calibration and link registers
  logic [9:0]         base_mm = 10'd100;
  logic [9:0]         lower_mm = 10'd150;
  logic [9:0]         upper_mm = 10'd150;
  logic [9:0]         lower_zero = 10'd0;
  logic [9:0]         upper_zero = 10'd0;
  logic signed [15:0] lower_dpc = 16'sd1474;
  logic signed [15:0] upper_dpc = 16'sd1474;

  sample_pair_t pending_pairs[$];
  position_t    expected_positions[$];
  int           gap_left = 0;
  bool_t        no_idle;
  int           fail_count = 0;

  // angle in q12 degrees to cos and sin in q30
  function automatic void cordic_trig(input longint ang_q12, output longint c,
                                      output longint s);
    longint turn, z, x, y, dx, dy;
    bit flip;
    turn = 360 * 65536;
    z = (ang_q12 * 16) % turn;
    flip = 0;
    x = 652032875;
    y = 0;
    if (z < 0) z += turn;
    if (z >= 180 * 65536) z -= turn;
    if (z > 90 * 65536) begin
      z -= 180 * 65536;
      flip = 1;
    end else if (z < -90 * 65536) begin
      z += 180 * 65536;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_q16(i));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_q16(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [15:0] round_clamp(input longint sum_q30, inout bit sat);
    longint v;
    v = (sum_q30 + (longint'(1) << 29)) >>> 30;
    if (v > 32767) begin
      v = 32767;
      sat = 1;
    end else if (v < -32768) begin
      v = -32768;
      sat = 1;
    end
    return v[15:0];
  endfunction

  function automatic position_t arm_position(input sample_pair_t p);
    position_t r;
    longint a1, a2, c1, s1, c2, s2, l1, l2, l3;
    bit sat;
    sat = 0;
    a1 = (longint'(p.lower) - longint'(lower_zero)) * longint'(lower_dpc);
    a2 = (longint'(p.upper) - longint'(upper_zero)) * longint'(upper_dpc);
    l1 = longint'(base_mm) * 16;
    l2 = longint'(lower_mm) * 16;
    l3 = longint'(upper_mm) * 16;
    cordic_trig(a1, c1, s1);
    cordic_trig(a1 + a2 - 90 * 4096, c2, s2);
    r.pos_x = round_clamp(l2 * c1 + l3 * c2, sat);
    r.pos_y = round_clamp(l1 * (longint'(1) << 30) + l2 * s1 + l3 * s2, sat);
    r.sat = sat;
    return r;
  endfunction

  // item driver
  always @(negedge clk) begin
    if (!rst_n || gap_left > 0 || pending_pairs.size() == 0) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      in_lower_sample <= pending_pairs[0].lower;
      in_upper_sample <= pending_pairs[0].upper;
    end
  end

  // acceptance and result checking
  always @(posedge clk) begin
    position_t e;
    if (rst_n && start && !busy) begin
      expected_positions.push_back(arm_position(pending_pairs.pop_front()));
      if ($urandom_range(0, 99) == 0) no_idle = !no_idle;
      gap_left = no_idle ? 0 : $urandom_range(0, 16);
    end else if (gap_left > 0) begin
      gap_left--;
    end
    if (rst_n && out_valid) begin
      if (expected_positions.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        e = expected_positions.pop_front();
        if (out_pos_x !== e.pos_x) begin
          $error("pos_x: expected %0d, got %0d", e.pos_x, out_pos_x);
          fail_count++;
        end
        if (out_pos_y !== e.pos_y) begin
          $error("pos_y: expected %0d, got %0d", e.pos_y, out_pos_y);
          fail_count++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, out_saturated);
          fail_count++;
        end
      end
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_BASE_LINK:  base_mm = value[9:0];
      REG_LOWER_LINK: lower_mm = value[9:0];
      REG_UPPER_LINK: upper_mm = value[9:0];
      REG_LOWER_ZERO: lower_zero = value[9:0];
      REG_UPPER_ZERO: upper_zero = value[9:0];
      REG_LOWER_DPC:  lower_dpc = value[15:0];
      REG_UPPER_DPC:  upper_dpc = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_arm(input logic [31:0] b, l, u, lz, uz, ld, ud);
    reg_write(REG_BASE_LINK, b);
    reg_write(REG_LOWER_LINK, l);
    reg_write(REG_UPPER_LINK, u);
    reg_write(REG_LOWER_ZERO, lz);
    reg_write(REG_UPPER_ZERO, uz);
    reg_write(REG_LOWER_DPC, ld);
    reg_write(REG_UPPER_DPC, ud);
    // unmapped index must change nothing
    reg_write(REG_NONE, $urandom());
  endtask

  task automatic push_pair(input int lo, input int up);
    sample_pair_t p;
    p.lower = lo[9:0];
    p.upper = up[9:0];
    pending_pairs.push_back(p);
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || expected_positions.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1023;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  initial begin
    no_idle = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: corners of the sample range and two interior pairs
    push_pair(0, 0);
    push_pair(1023, 1023);
    push_pair(0, 1023);
    push_pair(1023, 0);
    push_pair(512, 512);
    push_pair(256, 768);
    drain();

    // one degree per count: quadrant boundaries and wrap past a full turn
    set_arm(100, 150, 150, 0, 0, 4096, 4096);
    push_pair(90, 0);
    push_pair(180, 90);
    push_pair(270, 180);
    push_pair(360, 270);
    push_pair(450, 360);
    push_pair(720, 1023);
    push_pair(1000, 90);
    drain();

    // longest links and steepest slope: only pos_y can clamp
    set_arm(1023, 1023, 1023, 0, 0, 32767, 32767);
    push_pair(0, 0);
    push_pair(1023, 1023);
    push_pair(1, 1);
    push_pair(22, 1000);
    drain();

    // zero-length links and negative slope from the top zero count
    set_arm(0, 0, 0, 1023, 1023, 32'hFFFF8000, 32'hFFFF8000);
    push_pair(0, 0);
    push_pair(1023, 1023);
    push_pair(512, 1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      set_arm($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom(), $urandom());
      for (int n = 0; n < 193; n++) push_pair(pick_sample(), pick_sample());
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
